/* hdl/gbn_pkg.sv */
// Shared types, constants and slot arithmetic for the Go-Back-N engine.
package gbn_pkg;

    // Window and payload sizing; field widths are fixed by the transaction format.
    localparam int WINDOW_SLOTS    = 10;
    localparam int PAYLOAD_BYTES   = 256;
    localparam int SLOT_W          = 4;
    localparam int LEN_W           = 9;
    localparam int NUM_W           = 8;
    localparam int PERIOD_W        = 16;
    localparam int QLEN_W          = 8;
    localparam int CFG_INDEX_W     = 8;
    localparam int CFG_DATA_W      = 16;
    localparam int CMD_QUEUE_DEPTH = 2;

    // Protocol constants.
    localparam int MIN_FRAME_BYTES      = 5;
    localparam int FRAME_OVERHEAD_BYTES = 7;
    localparam int SEND_HEADER_BYTES    = 3;
    localparam int ACK_REPEAT           = 3;
    localparam int ACK_CNT_W            = $clog2(ACK_REPEAT);

    // Configuration register reset values and indexes.
    localparam logic [PERIOD_W-1:0]    DATA_TIMER_RESET      = PERIOD_W'(2000);
    localparam logic [QLEN_W-1:0]      QUEUE_LIMIT_RESET     = QLEN_W'(50);
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_TIMER_PERIOD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_QUEUE_LIMIT       = CFG_INDEX_W'(1);

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [1:0] {
        OP_LINK_READY = 2'd0,
        OP_NEW_PACKET = 2'd1,
        OP_FRAME      = 2'd2,
        OP_TIMER      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_ACK   = 2'd1,
        KIND_NAK   = 2'd2,
        KIND_OTHER = 2'd3
    } t_frame_kind;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_STORE   = 3'd1,
        ACT_SEND    = 3'd2,
        ACT_STOP    = 3'd3,
        ACT_ACK     = 3'd4,
        ACT_NAK     = 3'd5,
        ACT_DELIVER = 3'd6
    } t_action;

    // Classified event handed from the front end to the back end.
    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_LINK_READY = 3'd1,
        CMD_NEW_PACKET = 3'd2,
        CMD_NAK        = 3'd3,
        CMD_ACK_FRAME  = 3'd4,
        CMD_DATA_FRAME = 3'd5,
        CMD_REWIND     = 3'd6,
        CMD_TIMER_ACK  = 3'd7
    } t_cmd_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEND,
        BK_REWIND,
        BK_DATA
    } t_back_state;

    typedef struct packed {
        t_op                 operation;
        logic [LEN_W-1:0]    packet_length;
        logic [QLEN_W-1:0]   queue_length;
        logic [LEN_W-1:0]    frame_length;
        logic                crc_ok;
        t_frame_kind         frame_kind;
        logic [NUM_W-1:0]    rx_ack_num;
        logic [NUM_W-1:0]    frame_seq;
        logic [NUM_W-1:0]    timer_id;
    } t_in_item;

    typedef struct packed {
        t_action             action;
        t_slot               slot;
        logic [NUM_W-1:0]    ack_number;
        logic [LEN_W-1:0]    data_length;
        logic [PERIOD_W-1:0] timer_period;
        logic                accept_packets;
        logic                last;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind           kind;
        logic [NUM_W-1:0]    num;
        logic [LEN_W-1:0]    len;
        logic                send_now;
    } t_cmd;

    // Slot index plus one, modulo the window.
    function automatic t_slot next_slot(input t_slot p);
        return (p == SLOT_W'(WINDOW_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    // Slot index minus one, modulo the window.
    function automatic t_slot prev_slot(input t_slot p);
        return (p == '0) ? SLOT_W'(WINDOW_SLOTS - 1) : p - 1'b1;
    endfunction

    // Forward distance from b to a around the window.
    function automatic t_slot slot_dist(input t_slot a, input t_slot b);
        logic [SLOT_W:0] t;
        t = {1'b0, a} + (SLOT_W + 1)'(WINDOW_SLOTS) - {1'b0, b};
        if (t >= (SLOT_W + 1)'(WINDOW_SLOTS)) begin
            t = t - (SLOT_W + 1)'(WINDOW_SLOTS);
        end
        return t[SLOT_W-1:0];
    endfunction

endpackage

/* hdl/gbn_front.sv */
// Front end: accepts event transactions and classifies them into commands.
module gbn_front (
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  gbn_pkg::t_in_item             i_in_data,
    input  logic [gbn_pkg::QLEN_W-1:0]    i_queue_limit,
    output logic                          o_push_valid,
    input  logic                          i_push_ready,
    output gbn_pkg::t_cmd                 o_push_cmd
);

    logic [gbn_pkg::LEN_W-1:0] plen_sat;
    logic [gbn_pkg::LEN_W-1:0] dlen_raw;
    logic [gbn_pkg::LEN_W-1:0] dlen_sat;
    logic                      frame_bad;

    // The queue decides acceptance; classification is purely combinational.
    assign o_in_ready   = i_push_ready;
    assign o_push_valid = i_in_valid;

    // Length saturation and frame sanity checks.
    always_comb begin
        plen_sat = (i_in_data.packet_length > gbn_pkg::LEN_W'(gbn_pkg::PAYLOAD_BYTES))
                 ? gbn_pkg::LEN_W'(gbn_pkg::PAYLOAD_BYTES) : i_in_data.packet_length;
        dlen_raw = (i_in_data.frame_length >= gbn_pkg::LEN_W'(gbn_pkg::FRAME_OVERHEAD_BYTES))
                 ? i_in_data.frame_length - gbn_pkg::LEN_W'(gbn_pkg::FRAME_OVERHEAD_BYTES)
                 : '0;
        dlen_sat = (dlen_raw > gbn_pkg::LEN_W'(gbn_pkg::PAYLOAD_BYTES))
                 ? gbn_pkg::LEN_W'(gbn_pkg::PAYLOAD_BYTES) : dlen_raw;
        frame_bad = (i_in_data.frame_length < gbn_pkg::LEN_W'(gbn_pkg::MIN_FRAME_BYTES))
                  || !i_in_data.crc_ok;
    end

    // Event decoder: everything that does not depend on engine state is settled here.
    always_comb begin
        o_push_cmd          = '0;
        o_push_cmd.kind     = gbn_pkg::CMD_NONE;
        unique case (i_in_data.operation)
            gbn_pkg::OP_LINK_READY: begin
                o_push_cmd.kind = gbn_pkg::CMD_LINK_READY;
            end
            gbn_pkg::OP_NEW_PACKET: begin
                o_push_cmd.kind     = gbn_pkg::CMD_NEW_PACKET;
                o_push_cmd.len      = plen_sat;
                o_push_cmd.send_now = i_in_data.queue_length < i_queue_limit;
            end
            gbn_pkg::OP_FRAME: begin
                if (frame_bad) begin
                    o_push_cmd.kind = gbn_pkg::CMD_NAK;
                end else begin
                    unique case (i_in_data.frame_kind)
                        gbn_pkg::KIND_DATA: begin
                            o_push_cmd.kind = gbn_pkg::CMD_DATA_FRAME;
                            o_push_cmd.num  = i_in_data.frame_seq;
                            o_push_cmd.len  = dlen_sat;
                        end
                        gbn_pkg::KIND_ACK: begin
                            o_push_cmd.kind = gbn_pkg::CMD_ACK_FRAME;
                            o_push_cmd.num  = i_in_data.rx_ack_num;
                        end
                        gbn_pkg::KIND_NAK: begin
                            o_push_cmd.kind = gbn_pkg::CMD_REWIND;
                        end
                        default: begin
                            o_push_cmd.kind = gbn_pkg::CMD_NONE;
                        end
                    endcase
                end
            end
            gbn_pkg::OP_TIMER: begin
                if (i_in_data.timer_id > gbn_pkg::NUM_W'(gbn_pkg::WINDOW_SLOTS)) begin
                    o_push_cmd.kind = gbn_pkg::CMD_TIMER_ACK;
                    o_push_cmd.num  = i_in_data.timer_id
                                    - gbn_pkg::NUM_W'(gbn_pkg::WINDOW_SLOTS);
                end else begin
                    o_push_cmd.kind = gbn_pkg::CMD_REWIND;
                end
            end
            default: begin
                o_push_cmd.kind = gbn_pkg::CMD_NONE;
            end
        endcase
    end

endmodule

/* hdl/gbn_cmd_fifo.sv */
// Short command queue between the front end and the back end.
module gbn_cmd_fifo #(
    parameter int DEPTH = gbn_pkg::CMD_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  gbn_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output gbn_pkg::t_cmd o_pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gbn_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointer and fill-level bookkeeping.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

/* hdl/gbn_back.sv */
// Back end: window state and the sequencer that emits action transactions.
module gbn_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  gbn_pkg::t_cmd                 i_cmd,
    input  logic [gbn_pkg::PERIOD_W-1:0]  i_data_timer_period,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output gbn_pkg::t_out_item            o_out_data
);

    gbn_pkg::t_back_state               r_state;
    gbn_pkg::t_back_state               n_state;
    gbn_pkg::t_slot                     r_stp, n_stp;
    gbn_pkg::t_slot                     r_ou, n_ou;
    gbn_pkg::t_slot                     r_sp, n_sp;
    gbn_pkg::t_slot                     r_re, n_re;
    gbn_pkg::t_slot                     r_idx, n_idx;
    logic [gbn_pkg::ACK_CNT_W-1:0]      r_cnt, n_cnt;
    logic [gbn_pkg::NUM_W-1:0]          r_num, n_num;
    logic [gbn_pkg::LEN_W-1:0]          r_len, n_len;
    logic                               r_out_valid, n_out_valid;
    gbn_pkg::t_out_item                 r_out, n_out;
    logic [gbn_pkg::LEN_W-1:0]          r_slot_len [gbn_pkg::WINDOW_SLOTS];

    logic                               out_free;
    logic                               pop;
    logic                               window_open;
    logic                               send_ok;
    logic                               rewind_empty;
    logic                               ack_hit;
    logic                               ack_dup;
    logic                               data_hit;
    logic                               idx_last;
    logic                               emit;
    gbn_pkg::t_out_item                 item;
    logic                               slot_we;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cmd_ready = (r_state == gbn_pkg::BK_IDLE) && out_free;

    // Decisions shared by the next-state and output logic.
    always_comb begin
        out_free     = !r_out_valid || i_out_ready;
        pop          = (r_state == gbn_pkg::BK_IDLE) && i_cmd_valid && out_free;
        window_open  = gbn_pkg::next_slot(r_stp) != r_ou;
        send_ok      = gbn_pkg::slot_dist(r_sp, r_ou) < gbn_pkg::slot_dist(r_stp, r_ou);
        rewind_empty = r_ou == r_sp;
        ack_hit      = i_cmd.num == gbn_pkg::NUM_W'(r_ou);
        ack_dup      = i_cmd.num == gbn_pkg::NUM_W'(gbn_pkg::prev_slot(r_ou));
        data_hit     = i_cmd.num == gbn_pkg::NUM_W'(r_re);
        idx_last     = gbn_pkg::next_slot(r_idx) == r_sp;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbn_pkg::BK_IDLE: begin
                if (pop) begin
                    unique case (i_cmd.kind)
                        gbn_pkg::CMD_LINK_READY: begin
                            n_state = gbn_pkg::BK_SEND;
                        end
                        gbn_pkg::CMD_NEW_PACKET: begin
                            if (window_open && i_cmd.send_now) begin
                                n_state = gbn_pkg::BK_SEND;
                            end
                        end
                        gbn_pkg::CMD_ACK_FRAME: begin
                            if (!ack_hit && !ack_dup && !rewind_empty) begin
                                n_state = gbn_pkg::BK_REWIND;
                            end
                        end
                        gbn_pkg::CMD_DATA_FRAME: begin
                            if (data_hit) begin
                                n_state = gbn_pkg::BK_DATA;
                            end
                        end
                        gbn_pkg::CMD_REWIND: begin
                            if (!rewind_empty) begin
                                n_state = gbn_pkg::BK_REWIND;
                            end
                        end
                        default: begin
                            n_state = gbn_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            gbn_pkg::BK_SEND: begin
                if (out_free) begin
                    if (send_ok || rewind_empty) begin
                        n_state = gbn_pkg::BK_IDLE;
                    end else begin
                        n_state = gbn_pkg::BK_REWIND;
                    end
                end
            end
            gbn_pkg::BK_REWIND: begin
                if (out_free && idx_last) begin
                    n_state = gbn_pkg::BK_IDLE;
                end
            end
            gbn_pkg::BK_DATA: begin
                if (out_free && (r_cnt == '0)) begin
                    n_state = gbn_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = gbn_pkg::BK_IDLE;
            end
        endcase
    end

    // Outputs: the action to emit and the window updates that go with it.
    always_comb begin
        n_stp       = r_stp;
        n_ou        = r_ou;
        n_sp        = r_sp;
        n_re        = r_re;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_num       = r_num;
        n_len       = r_len;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        emit        = 1'b0;
        slot_we     = 1'b0;
        item        = '0;
        item.action = gbn_pkg::ACT_NONE;
        item.last   = 1'b1;

        unique case (r_state)
            gbn_pkg::BK_IDLE: begin
                if (pop) begin
                    n_num = i_cmd.num;
                    n_len = i_cmd.len;
                    emit  = 1'b1;
                    unique case (i_cmd.kind)
                        gbn_pkg::CMD_LINK_READY: begin
                            emit = 1'b0;
                        end
                        gbn_pkg::CMD_NEW_PACKET: begin
                            if (window_open) begin
                                item.action      = gbn_pkg::ACT_STORE;
                                item.slot        = r_stp;
                                item.data_length = i_cmd.len;
                                item.last        = !i_cmd.send_now;
                                slot_we          = 1'b1;
                                n_stp            = gbn_pkg::next_slot(r_stp);
                            end
                        end
                        gbn_pkg::CMD_NAK: begin
                            item.action = gbn_pkg::ACT_NAK;
                        end
                        gbn_pkg::CMD_ACK_FRAME: begin
                            if (ack_hit) begin
                                if (!rewind_empty) begin
                                    item.action = gbn_pkg::ACT_STOP;
                                    item.slot   = r_ou;
                                    n_ou        = gbn_pkg::next_slot(r_ou);
                                end
                            end else if (!ack_dup && !rewind_empty) begin
                                emit  = 1'b0;
                                n_idx = r_ou;
                            end
                        end
                        gbn_pkg::CMD_DATA_FRAME: begin
                            if (data_hit) begin
                                item.action     = gbn_pkg::ACT_ACK;
                                item.ack_number = i_cmd.num;
                                item.last       = 1'b0;
                                n_cnt = gbn_pkg::ACK_CNT_W'(gbn_pkg::ACK_REPEAT - 1);
                            end
                        end
                        gbn_pkg::CMD_REWIND: begin
                            if (!rewind_empty) begin
                                emit  = 1'b0;
                                n_idx = r_ou;
                            end
                        end
                        gbn_pkg::CMD_TIMER_ACK: begin
                            item.action     = gbn_pkg::ACT_ACK;
                            item.ack_number = i_cmd.num;
                        end
                        default: begin
                            item.action = gbn_pkg::ACT_NONE;
                        end
                    endcase
                end
            end
            gbn_pkg::BK_SEND: begin
                if (out_free) begin
                    if (send_ok) begin
                        emit              = 1'b1;
                        item.action       = gbn_pkg::ACT_SEND;
                        item.slot         = r_sp;
                        item.data_length  = gbn_pkg::LEN_W'(gbn_pkg::SEND_HEADER_BYTES)
                                          + r_slot_len[r_sp];
                        item.timer_period = i_data_timer_period;
                        n_sp              = gbn_pkg::next_slot(r_sp);
                    end else if (rewind_empty) begin
                        emit = 1'b1;
                    end else begin
                        n_idx = r_ou;
                    end
                end
            end
            gbn_pkg::BK_REWIND: begin
                if (out_free) begin
                    emit        = 1'b1;
                    item.action = gbn_pkg::ACT_STOP;
                    item.slot   = r_idx;
                    item.last   = idx_last;
                    n_idx       = gbn_pkg::next_slot(r_idx);
                    if (idx_last) begin
                        n_sp = r_ou;
                    end
                end
            end
            gbn_pkg::BK_DATA: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_cnt != '0) begin
                        item.action     = gbn_pkg::ACT_ACK;
                        item.ack_number = r_num;
                        item.last       = 1'b0;
                        n_cnt           = r_cnt - 1'b1;
                    end else begin
                        item.action      = gbn_pkg::ACT_DELIVER;
                        item.data_length = r_len;
                        n_re             = gbn_pkg::next_slot(r_re);
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        // Every action of an event reports the window state after the event.
        if (emit) begin
            item.accept_packets = gbn_pkg::next_slot(n_stp) != n_ou;
            n_out_valid         = 1'b1;
            n_out               = item;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gbn_pkg::BK_IDLE;
            r_stp       <= '0;
            r_ou        <= '0;
            r_sp        <= '0;
            r_re        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stp       <= n_stp;
            r_ou        <= n_ou;
            r_sp        <= n_sp;
            r_re        <= n_re;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_len <= n_len;
        r_out <= n_out;
    end

    // Stored payload length of each window slot.
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_len[r_stp] <= i_cmd.len;
        end
    end

    // The send pointer never runs ahead of the store pointer.
    a_send_within_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gbn_pkg::slot_dist(r_sp, r_ou) <= gbn_pkg::slot_dist(r_stp, r_ou))
        else $error("send pointer left the window");

    // A rewind pass always has an unsent slot ahead of it.
    a_rewind_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gbn_pkg::BK_REWIND) |-> (r_idx != r_sp))
        else $error("rewind index reached the send pointer");

    // An empty action only ever stands alone.
    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.action == gbn_pkg::ACT_NONE)) |-> r_out.last)
        else $error("empty action not marked last");

    // The window never fills past one free slot.
    a_window_not_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_stp != gbn_pkg::prev_slot(r_ou)) |-> (r_stp != r_ou) || (r_sp == r_ou))
        else $error("store pointer overran the window");

endmodule

/* hdl/go_back_n_arq_engine.sv */
// Top level of the Go-Back-N ARQ control engine: configuration, front end, queue, back end.
//
// Each event transaction (link ready, new packet, received frame, timer expiry) is
// classified by the front end in the cycle it is accepted and placed in a short command
// queue, so new events are taken while the back end is still emitting actions. The back
// end emits one action transaction per cycle into an output register while that register
// is free. An event with a single store, ACK, NAK, stop or empty action emits it as it is
// decided; link ready first decides and then sends, a new packet with an immediate send
// is stored and then sent, an in-order data frame gives three ACKs and a delivery, and
// a window rewind first decides and then gives one stop per outstanding slot; a link
// ready that finds nothing to send decides once more before its rewind. The back-end
// sequencer is shared by all events.
// Configuration writes are taken at any time and must only be issued while the engine
// is idle.
module go_back_n_arq_engine #(
    parameter int CMD_DEPTH = gbn_pkg::CMD_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  gbn_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output gbn_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gbn_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [gbn_pkg::PERIOD_W-1:0] r_data_timer_period;
    logic [gbn_pkg::QLEN_W-1:0]   r_queue_limit;
    logic                         push_valid;
    logic                         push_ready;
    gbn_pkg::t_cmd                push_cmd;
    logic                         pop_valid;
    logic                         pop_ready;
    gbn_pkg::t_cmd                pop_cmd;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_timer_period <= gbn_pkg::DATA_TIMER_RESET;
            r_queue_limit       <= gbn_pkg::QUEUE_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                gbn_pkg::CFG_DATA_TIMER_PERIOD: begin
                    r_data_timer_period <= i_cfg_data[gbn_pkg::PERIOD_W-1:0];
                end
                gbn_pkg::CFG_QUEUE_LIMIT: begin
                    r_queue_limit <= i_cfg_data[gbn_pkg::QLEN_W-1:0];
                end
                default: begin
                    r_queue_limit <= r_queue_limit;
                end
            endcase
        end
    end

    // Event classification.
    gbn_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_queue_limit (r_queue_limit),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_push_cmd    (push_cmd)
    );

    // Command queue.
    gbn_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_cmd    (pop_cmd)
    );

    // Window state and action sequencing.
    gbn_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd_valid         (pop_valid),
        .o_cmd_ready         (pop_ready),
        .i_cmd               (pop_cmd),
        .i_data_timer_period (r_data_timer_period),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_out_data          (o_out_data)
    );

endmodule
